### rtl/core/spfd_pkg.sv
// Package for the servo pulse to FET drive core.
// Holds field widths, reset values, register indexes and the item types.
// No dependencies.
package spfd_pkg;

	localparam int WIDTH      = 16;
	localparam int DAMP_SHIFT = 7;
	localparam int QW         = WIDTH - 2;
	localparam int LIM_W      = 8;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIDTH-1:0]  SMOOTH_RESET      = WIDTH'(1000);
	localparam logic [WIDTH-1:0]  CENTER_RESET      = WIDTH'(1050);
	localparam logic [LIM_W-1:0]  ON_LIMIT_RESET    = LIM_W'(10);
	localparam logic [LIM_W-1:0]  PULSE_LIMIT_RESET = LIM_W'(70);
	localparam logic [LIM_W-1:0]  OFF_LIMIT_RESET   = LIM_W'(80);
	localparam logic [LIM_W-1:0]  FLASH_LIMIT_RESET = LIM_W'(120);
	localparam logic [TICK_W-1:0] FLASH_TICKS_RESET = TICK_W'(1800);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_OFFSET  = 3'd0,
		CFG_ON_LIMIT       = 3'd1,
		CFG_PULSE_LIMIT    = 3'd2,
		CFG_OFF_LIMIT      = 3'd3,
		CFG_FLASH_LIMIT    = 3'd4,
		CFG_FLASH_ON_TICKS = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		GATE_HOLD  = 2'd0,
		GATE_ON    = 2'd1,
		GATE_OFF   = 2'd2,
		GATE_TIMED = 2'd3
	} gate_mode_t;

	typedef struct packed {
		logic [WIDTH-1:0]  center_offset;
		logic [LIM_W-1:0]  on_limit;
		logic [LIM_W-1:0]  pulse_limit;
		logic [LIM_W-1:0]  off_limit;
		logic [LIM_W-1:0]  flash_limit;
		logic [TICK_W-1:0] flash_on_ticks;
	} cfg_t;

	typedef struct packed {
		logic [15:0] pulse_width;
	} in_item_t;

	typedef struct packed {
		gate_mode_t  gate_mode;
		logic [15:0] on_ticks;
		logic [15:0] smoothed_width;
	} out_item_t;

endpackage

### rtl/core/spfd_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is a parameter; used with spfd_pkg item types.
interface spfd_chan_if #(
	parameter type payload_t = spfd_pkg::in_item_t
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/servo_pulse_to_fet_drive_core.sv
// Servo pulse to FET drive core: top level.
// Depends on spfd_pkg, spfd_chan_if, spfd_cfg_regs and spfd_step.
//
// Use: each transfer on in_ch carries one measured servo pulse width. For
// each one the core returns one item on out_ch: the gate mode, the on time
// for a timed pulse and the smoothed width after the update.
// Pipeline: each input transfer is captured in the input register, and
// the step result in the result register, which drives out_ch. Throughput:
// one item per cycle while out_ch is ready; the smoothing and skip state
// is updated as an item moves from the input register to the result
// register, so consecutive items follow with no gap.
// Stall: while out_ch is not ready, a held result blocks the step, and
// in_ch.ready drops only once the input register is also occupied.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one register per cycle.
// Write only while no item is in flight; the core does no check of it.
// Reset: arst_n clears both pipeline stages, sets the smoothed width to
// 1000, the skip count to zero and all registers to their defaults.
module servo_pulse_to_fet_drive_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	spfd_chan_if.sink                       in_ch,
	spfd_chan_if.source                     out_ch
);
	spfd_pkg::cfg_t              cfg;
	logic                        valid_s1;
	logic [spfd_pkg::WIDTH-1:0]  sample_s1;
	logic                        out_valid_q;
	spfd_pkg::out_item_t         out_data_q;
	logic [spfd_pkg::WIDTH-1:0]  smoothed_q;
	logic [spfd_pkg::LIM_W-1:0]  skip_q;
	logic [spfd_pkg::WIDTH-1:0]  smoothed_nxt;
	logic [spfd_pkg::LIM_W-1:0]  skip_nxt;
	spfd_pkg::out_item_t         result;
	logic                        out_free;
	logic                        step_fire;
	logic                        in_xfer;

	spfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spfd_step u_step (
		.sample       (sample_s1),
		.smoothed     (smoothed_q),
		.skip_left    (skip_q),
		.cfg          (cfg),
		.smoothed_nxt (smoothed_nxt),
		.skip_nxt     (skip_nxt),
		.result       (result)
	);

	assign out_free    = !out_valid_q || out_ch.ready;
	assign step_fire   = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			smoothed_q  <= spfd_pkg::SMOOTH_RESET;
			skip_q      <= '0;
		end else begin
			if (in_ch.ready)
				valid_s1 <= in_ch.valid;
			if (out_free)
				out_valid_q <= valid_s1;
			if (step_fire) begin
				smoothed_q <= smoothed_nxt;
				skip_q     <= skip_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			sample_s1 <= spfd_pkg::WIDTH'(in_ch.data.pulse_width);
		if (step_fire)
			out_data_q <= result;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	a_ticks_only_timed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.gate_mode != spfd_pkg::GATE_TIMED
		|-> out_data_q.on_ticks == '0)
		else $error("on_ticks set outside a timed pulse");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_fire |=> $stable(smoothed_q) && $stable(skip_q))
		else $error("step state changed without a step");

	a_skip_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire && skip_q != '0
		|=> skip_q == spfd_pkg::LIM_W'($past(skip_q) - spfd_pkg::LIM_W'(1)))
		else $error("skip count did not decrement");

	a_skip_holds_gate: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire && skip_q != '0
		|=> out_valid_q && out_data_q.gate_mode == spfd_pkg::GATE_HOLD)
		else $error("gate changed while skipping");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> out_valid_q && out_data_q.smoothed_width == 16'(smoothed_q))
		else $error("result smoothed width differs from state");
endmodule

### rtl/core/spfd_cfg_regs.sv
// Configuration register file of the servo pulse to FET drive core.
// Depends on spfd_pkg. Writes to unknown indexes are dropped.
module spfd_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [spfd_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [spfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output spfd_pkg::cfg_t                       cfg
);
	spfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_offset  <= spfd_pkg::CENTER_RESET;
			cfg_q.on_limit       <= spfd_pkg::ON_LIMIT_RESET;
			cfg_q.pulse_limit    <= spfd_pkg::PULSE_LIMIT_RESET;
			cfg_q.off_limit      <= spfd_pkg::OFF_LIMIT_RESET;
			cfg_q.flash_limit    <= spfd_pkg::FLASH_LIMIT_RESET;
			cfg_q.flash_on_ticks <= spfd_pkg::FLASH_TICKS_RESET;
		end else if (cfg_we) begin
			case (spfd_pkg::cfg_idx_t'(cfg_idx))
				spfd_pkg::CFG_CENTER_OFFSET:
					cfg_q.center_offset <= spfd_pkg::WIDTH'(cfg_wdata);
				spfd_pkg::CFG_ON_LIMIT:
					cfg_q.on_limit <= cfg_wdata[spfd_pkg::LIM_W-1:0];
				spfd_pkg::CFG_PULSE_LIMIT:
					cfg_q.pulse_limit <= cfg_wdata[spfd_pkg::LIM_W-1:0];
				spfd_pkg::CFG_OFF_LIMIT:
					cfg_q.off_limit <= cfg_wdata[spfd_pkg::LIM_W-1:0];
				spfd_pkg::CFG_FLASH_LIMIT:
					cfg_q.flash_limit <= cfg_wdata[spfd_pkg::LIM_W-1:0];
				spfd_pkg::CFG_FLASH_ON_TICKS:
					cfg_q.flash_on_ticks <= cfg_wdata[spfd_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

### rtl/core/spfd_step.sv
// Single-pass step logic: smoothing update, quantising and gate decision.
// Depends on spfd_pkg. Purely combinational.
module spfd_step (
	input  logic [spfd_pkg::WIDTH-1:0]  sample,
	input  logic [spfd_pkg::WIDTH-1:0]  smoothed,
	input  logic [spfd_pkg::LIM_W-1:0]  skip_left,
	input  spfd_pkg::cfg_t              cfg,
	output logic [spfd_pkg::WIDTH-1:0]  smoothed_nxt,
	output logic [spfd_pkg::LIM_W-1:0]  skip_nxt,
	output spfd_pkg::out_item_t         result
);
	logic [spfd_pkg::WIDTH-1:0]  step_amt;
	logic [spfd_pkg::WIDTH-1:0]  grown;
	logic [spfd_pkg::WIDTH-1:0]  shrunk;
	logic [spfd_pkg::WIDTH-1:0]  diff;
	logic [spfd_pkg::QW-1:0]     q;
	logic [spfd_pkg::LIM_W-1:0]  p;
	logic [spfd_pkg::LIM_W:0]    p_plus;
	logic [spfd_pkg::LIM_W-1:0]  half;
	logic [2*spfd_pkg::LIM_W-1:0] prod;

	always_comb begin
		step_amt = smoothed >> spfd_pkg::DAMP_SHIFT;
		grown    = smoothed + step_amt;
		shrunk   = smoothed - step_amt;
		if (sample > smoothed)
			smoothed_nxt = (grown > sample) ? sample : grown;
		else
			smoothed_nxt = (shrunk < sample) ? sample : shrunk;

		diff   = smoothed_nxt - cfg.center_offset;
		q      = diff[spfd_pkg::WIDTH-1:2];
		p      = cfg.pulse_limit - q[spfd_pkg::LIM_W-1:0];
		p_plus = {1'b0, p} + (spfd_pkg::LIM_W+1)'(2);
		half   = p_plus[spfd_pkg::LIM_W:1];
		prod   = p * half;

		result.gate_mode      = spfd_pkg::GATE_HOLD;
		result.on_ticks       = '0;
		result.smoothed_width = 16'(smoothed_nxt);
		skip_nxt              = skip_left;

		if (skip_left != '0) begin
			skip_nxt = skip_left - spfd_pkg::LIM_W'(1);
		end else if (q <= spfd_pkg::QW'(cfg.on_limit)) begin
			result.gate_mode = spfd_pkg::GATE_ON;
		end else if (q <= spfd_pkg::QW'(cfg.pulse_limit)) begin
			result.gate_mode = spfd_pkg::GATE_TIMED;
			result.on_ticks  = 16'(prod);
		end else if (q <= spfd_pkg::QW'(cfg.off_limit)) begin
			result.gate_mode = spfd_pkg::GATE_OFF;
		end else if (q <= spfd_pkg::QW'(cfg.flash_limit)) begin
			result.gate_mode = spfd_pkg::GATE_TIMED;
			result.on_ticks  = 16'(cfg.flash_on_ticks);
			skip_nxt         = cfg.flash_limit - q[spfd_pkg::LIM_W-1:0];
		end
	end
endmodule
